@@ src/raster_fill_and_sprite_blit_core_assert.svh @@
// Assertion macros used by the raster engine walker.
// Each macro expands to a labeled concurrent assertion in simulation
// and to nothing in synthesis.
`ifndef RASTER_FILL_AND_SPRITE_BLIT_CORE_ASSERT_SVH
`define RASTER_FILL_AND_SPRITE_BLIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge, skipped while reset is high.
`define RFSB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rfsb assertion failed");
// Check a property at every rising edge, reset included.
`define RFSB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rfsb assertion failed");
`else
`define RFSB_ASSERT(lbl, clk, rst, prop)
`define RFSB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ src/rfsb_pkg.sv @@
`timescale 1ns / 1ps
package rfsb_pkg;

  localparam int DEF_MAX_SCREEN_WIDTH  = 256;
  localparam int DEF_MAX_SCREEN_HEIGHT = 256;
  localparam int DEF_SPRITE_WORDS      = 4096;

  // Widest frame address over the parameter range, and raw sprite address width
  localparam int FA_MAX_W   = 24;
  localparam int SPR_RAW_W  = 14;
  localparam int SPR_ADDR_W = 16;
  localparam int COLOR_W    = 32;

  typedef enum logic [2:0] {
    OP_FILL        = 3'd0,
    OP_CLEAR       = 3'd1,
    OP_BLIT        = 3'd2,
    OP_BLIT_MIRROR = 3'd3,
    OP_LOAD        = 3'd4,
    OP_READ        = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_SPRITE_WIDTH  = 2'd2,
    REG_SPRITE_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SETUP2,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_t;

  // One pixel job handed from the walker to the write-back pipeline
  typedef struct packed {
    logic                  valid;
    logic                  blit;
    logic [FA_MAX_W-1:0]   frame_addr;
    logic [SPR_RAW_W-1:0]  sprite_raw;
    logic [COLOR_W-1:0]    color;
  } pix_t;

  typedef struct packed {
    logic                en;
    logic [FA_MAX_W-1:0] addr;
  } frame_rd_t;

  typedef struct packed {
    logic                  en;
    logic [SPR_ADDR_W-1:0] addr;
    logic [COLOR_W-1:0]    data;
  } sprite_wr_t;

  // Clamp a signed edge into 0 .. hi
  function automatic logic [15:0] clamp_edge(input logic signed [15:0] v,
                                             input logic [15:0] hi);
    logic [15:0] u;
    u = v;
    if (v[15]) return '0;
    else if (u > hi) return hi;
    else return u;
  endfunction

endpackage

@@ src/raster_fill_and_sprite_blit_core.sv @@
`timescale 1ns / 1ps
// Channel   Handshake        Ports
// command   start / busy     op x_start x_end y_start y_end scale color sprite_index
// config    cfg_we           cfg_index cfg_data
// result    done (strobe)    read_color status
//
// One command at a time: busy rises the cycle after start is taken.
// Fills and blits pass through setup, a row-by-row walk of their clipped area,
// address pipeline drain and result; the walker sets the rate. Other commands
// skip the walk (setup, address pipeline drain, result). Synchronous reset clears
// control, valid bits and configuration registers; memories are not cleared.
// done is high for one cycle; the receiver cannot stall.
module raster_fill_and_sprite_blit_core #(
  parameter int MAX_SCREEN_WIDTH  = rfsb_pkg::DEF_MAX_SCREEN_WIDTH,
  parameter int MAX_SCREEN_HEIGHT = rfsb_pkg::DEF_MAX_SCREEN_HEIGHT,
  parameter int SPRITE_WORDS      = rfsb_pkg::DEF_SPRITE_WORDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic signed [15:0] x_start,
  input  logic signed [15:0] x_end,
  input  logic signed [15:0] y_start,
  input  logic signed [15:0] y_end,
  input  logic [3:0]         scale,
  input  logic [31:0]        color,
  input  logic [11:0]        sprite_index,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  output logic               done,
  output logic [31:0]        read_color,
  output logic [1:0]         status
);
  import rfsb_pkg::*;

  localparam int FRAME_WORDS = MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT;
  localparam int FA_W   = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int SPR_AW = (SPRITE_WORDS > 1) ? $clog2(SPRITE_WORDS) : 1;
  localparam int K_MID  = 7;

  pix_t       pix, pa, pb, pc;
  frame_rd_t  frame_rd;
  sprite_wr_t sprite_wr;
  logic [31:0] frame_rdata, sprite_rdata;
  logic        frame_we;
  logic [31:0] frame_wdata;

  // Reduce a raw sprite address modulo the store size, shifts k_lo .. k_hi
  function automatic logic [SPR_RAW_W-1:0] spr_reduce(input logic [SPR_RAW_W-1:0] v,
                                                      input int k_lo, input int k_hi);
    int r;
    r = int'(v);
    for (int k = SPR_RAW_W - 1; k >= 0; k--) begin
      if ((k >= k_lo) && (k <= k_hi) && ((SPRITE_WORDS << k) < (1 << SPR_RAW_W)) &&
          (r >= (SPRITE_WORDS << k)))
        r = r - (SPRITE_WORDS << k);
    end
    return SPR_RAW_W'(r);
  endfunction

  rfsb_walk #(
    .MAX_SCREEN_WIDTH  (MAX_SCREEN_WIDTH),
    .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT),
    .SPRITE_WORDS      (SPRITE_WORDS)
  ) u_walk (
    .clk, .rst, .start, .busy, .op, .x_start, .x_end, .y_start, .y_end,
    .scale, .color, .sprite_index, .cfg_we, .cfg_index, .cfg_data,
    .frame_rdata, .pix, .frame_rd, .sprite_wr, .done, .read_color, .status
  );

  // Pixel pipeline: reset valid bits, reduce sprite address in two halves
  always_ff @(posedge clk) begin
    if (rst) begin
      pa.valid <= 1'b0;
      pb.valid <= 1'b0;
      pc.valid <= 1'b0;
    end else begin
      pa.valid <= pix.valid;
      pb.valid <= pa.valid;
      pc.valid <= pb.valid;
    end
    pa.blit       <= pix.blit;
    pa.frame_addr <= pix.frame_addr;
    pa.color      <= pix.color;
    pa.sprite_raw <= spr_reduce(pix.sprite_raw, K_MID, SPR_RAW_W - 1);
    pb.blit       <= pa.blit;
    pb.frame_addr <= pa.frame_addr;
    pb.color      <= pa.color;
    pb.sprite_raw <= spr_reduce(pa.sprite_raw, 0, K_MID - 1);
    pc.blit       <= pb.blit;
    pc.frame_addr <= pb.frame_addr;
    pc.color      <= pb.color;
    pc.sprite_raw <= pb.sprite_raw;
  end

  // Write back: fills always, blits only where the sprite differs from the key
  assign frame_we    = pc.valid && (!pc.blit || (sprite_rdata != pc.color));
  assign frame_wdata = pc.blit ? sprite_rdata : pc.color;

  rfsb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (SPRITE_WORDS)
  ) u_sprite_ram (
    .clk,
    .we    (sprite_wr.en),
    .waddr (SPR_AW'(sprite_wr.addr)),
    .wdata (sprite_wr.data),
    .re    (pb.valid && pb.blit),
    .raddr (SPR_AW'(pb.sprite_raw)),
    .rdata (sprite_rdata)
  );

  rfsb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (FRAME_WORDS)
  ) u_frame_ram (
    .clk,
    .we    (frame_we),
    .waddr (FA_W'(pc.frame_addr)),
    .wdata (frame_wdata),
    .re    (frame_rd.en),
    .raddr (FA_W'(frame_rd.addr)),
    .rdata (frame_rdata)
  );

endmodule

@@ src/rfsb_ram.sv @@
`timescale 1ns / 1ps
module rfsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ src/rfsb_walk.sv @@
`timescale 1ns / 1ps
`include "raster_fill_and_sprite_blit_core_assert.svh"
module rfsb_walk #(
  parameter int MAX_SCREEN_WIDTH  = 256,
  parameter int MAX_SCREEN_HEIGHT = 256,
  parameter int SPRITE_WORDS      = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            op,
  input  logic signed [15:0]    x_start,
  input  logic signed [15:0]    x_end,
  input  logic signed [15:0]    y_start,
  input  logic signed [15:0]    y_end,
  input  logic [3:0]            scale,
  input  logic [31:0]           color,
  input  logic [11:0]           sprite_index,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [8:0]            cfg_data,
  input  logic [31:0]           frame_rdata,
  output rfsb_pkg::pix_t        pix,
  output rfsb_pkg::frame_rd_t   frame_rd,
  output rfsb_pkg::sprite_wr_t  sprite_wr,
  output logic                  done,
  output logic [31:0]           read_color,
  output logic [1:0]            status
);
  import rfsb_pkg::*;

  localparam int XW   = $clog2(MAX_SCREEN_WIDTH + 1);
  localparam int YW   = $clog2(MAX_SCREEN_HEIGHT + 1);
  localparam int FR_W = $clog2(MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT + 1);
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_t state, state_next;
  logic [1:0] drain_cnt;

  logic [8:0] scr_w, scr_h;
  logic [6:0] spr_w, spr_h;

  logic [2:0]         c_op;
  logic signed [15:0] c_xs, c_xe, c_ys, c_ye;
  logic [3:0]         c_scale;
  logic [31:0]        c_color;
  logic [11:0]        c_idx;

  logic [XW-1:0]   x, x_lo, x_hi;
  logic [YW-1:0]   y, y_hi;
  logic [19:0]     col_lo, col0, row_lo;
  logic [FR_W-1:0] frow;
  logic [13:0]     srow, stride;

  logic [XW-1:0] act_w, x0c, x1c;
  logic [YW-1:0] act_h, y0c, y1c;
  logic [16:0]   dx0, dy0;
  logic [19:0]   col0_val, row0_val;
  logic [FR_W-1:0] frow_val;
  logic [3:0]    half;
  logic [6:0]    rs7, col_s, col_sel;
  logic [20:0]   col_end, row_end;
  logic          is_blit, is_mirror, is_clear, is_area, ignored, rd_inr;
  logic          xin, yin, accept;

  assign accept    = start && !busy;
  assign is_blit   = (c_op == OP_BLIT) || (c_op == OP_BLIT_MIRROR);
  assign is_mirror = (c_op == OP_BLIT_MIRROR);
  assign is_clear  = (c_op == OP_CLEAR);
  assign ignored   = is_blit && (c_scale == 4'd0);
  assign is_area   = (c_op == OP_FILL) || is_clear || (is_blit && !ignored);
  assign half      = c_scale >> 1;

  // Saturate the active screen to the store size
  assign act_w = (int'(scr_w) > MAX_SCREEN_WIDTH)  ? XW'(MAX_SCREEN_WIDTH)  : XW'(scr_w);
  assign act_h = (int'(scr_h) > MAX_SCREEN_HEIGHT) ? YW'(MAX_SCREEN_HEIGHT) : YW'(scr_h);

  // Clamp the rectangle corners and find the first sample offsets
  always_comb begin
    x0c = is_clear ? '0 : XW'(clamp_edge(c_xs, 16'(act_w)));
    x1c = is_clear ? act_w : XW'(clamp_edge(c_xe, 16'(act_w)));
    y0c = is_clear ? '0 : YW'(clamp_edge(c_ys, 16'(act_h)));
    y1c = is_clear ? act_h : YW'(clamp_edge(c_ye, 16'(act_h)));
    dx0 = {1'b0, 16'(x0c)} - {c_xs[15], c_xs};
    dy0 = {1'b0, 16'(y0c)} - {c_ys[15], c_ys};
    col0_val = {4'b0, dx0[15:0]} * {16'b0, c_scale};
    row0_val = {4'b0, dy0[15:0]} * {16'b0, c_scale};
    frow_val = FR_W'(y0c) * FR_W'(act_w);
  end

  // Range tests of the current pixel and row
  always_comb begin
    col_end = {1'b0, col_lo} + 21'(c_scale);
    row_end = {1'b0, row_lo} + 21'(c_scale);
    xin = is_blit ? ((x < act_w) && (col_end <= 21'(spr_w))) : (x < x_hi);
    yin = is_blit ? ((y < act_h) && (row_end <= 21'(spr_h))) : (y < y_hi);
    rd_inr = !c_xs[15] && ($unsigned(c_xs) < 16'(act_w)) &&
             !c_ys[15] && ($unsigned(c_ys) < 16'(act_h));
    rs7     = row_lo[6:0] + 7'(half);
    col_s   = col_lo[6:0] + 7'(half);
    col_sel = is_mirror ? (spr_w - 7'd1 - col_s) : col_s;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SETUP;
      S_SETUP:  state_next = S_SETUP2;
      S_SETUP2: state_next = is_area ? S_WALK : S_DRAIN;
      S_WALK:   if (!yin) state_next = S_DRAIN;
      S_DRAIN:  if (drain_cnt == DRAIN_LAST) state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_DONE);
    pix.valid      = (state == S_WALK) && yin && xin;
    pix.blit       = is_blit;
    pix.frame_addr = FA_MAX_W'(frow + FR_W'(x));
    pix.sprite_raw = srow + {7'b0, col_sel};
    pix.color      = c_color;
    frame_rd.en    = (state == S_SETUP2) && (c_op == OP_READ);
    frame_rd.addr  = FA_MAX_W'(frow + FR_W'(x));
    sprite_wr.en   = (state == S_SETUP2) && (c_op == OP_LOAD) &&
                     (int'(c_idx) < SPRITE_WORDS);
    sprite_wr.addr = SPR_ADDR_W'(c_idx);
    sprite_wr.data = c_color;
    read_color     = ((c_op == OP_READ) && rd_inr) ? frame_rdata : '0;
    if (ignored) status = ST_IGNORED;
    else if ((c_op == OP_READ) && !rd_inr) status = ST_OUTSIDE;
    else status = ST_DONE;
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      drain_cnt <= '0;
      scr_w     <= '0;
      scr_h     <= '0;
      spr_w     <= '0;
      spr_h     <= '0;
    end else begin
      state     <= state_next;
      drain_cnt <= (state == S_DRAIN) ? drain_cnt + 2'd1 : '0;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_SCREEN_WIDTH:  scr_w <= cfg_data;
          REG_SCREEN_HEIGHT: scr_h <= cfg_data;
          REG_SPRITE_WIDTH:  spr_w <= cfg_data[6:0];
          REG_SPRITE_HEIGHT: spr_h <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  // Command capture and walk counters
  always_ff @(posedge clk) begin
    if (accept) begin
      c_op    <= op;
      c_xs    <= x_start;
      c_xe    <= x_end;
      c_ys    <= y_start;
      c_ye    <= y_end;
      c_scale <= scale;
      c_color <= color;
      c_idx   <= sprite_index;
    end
    if (state == S_SETUP) begin
      x      <= x0c;
      x_lo   <= x0c;
      x_hi   <= x1c;
      y      <= y0c;
      y_hi   <= y1c;
      col_lo <= col0_val;
      col0   <= col0_val;
      row_lo <= row0_val;
      frow   <= frow_val;
    end
    if (state == S_SETUP2) begin
      srow   <= {7'b0, rs7} * {7'b0, spr_w};
      stride <= {10'b0, c_scale} * {7'b0, spr_w};
    end
    // Advance along the row, or wrap to the next row
    if ((state == S_WALK) && yin) begin
      if (xin) begin
        x      <= x + XW'(1);
        col_lo <= col_lo + 20'(c_scale);
      end else begin
        x      <= x_lo;
        col_lo <= col0;
        y      <= y + YW'(1);
        row_lo <= row_lo + 20'(c_scale);
        frow   <= frow + FR_W'(act_w);
        srow   <= srow + stride;
      end
    end
  end

  `RFSB_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !busy)
  `RFSB_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `RFSB_ASSERT(a_ignored_quiet, clk, rst, pix.valid |-> !ignored)
  `RFSB_ASSERT(a_done_single, clk, rst, done |=> !done)
  `RFSB_ASSERT(a_read_only_op, clk, rst, frame_rd.en |-> (c_op == OP_READ))

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import rfsb_pkg::*;

  // Op codes the block leaves undefined; they must answer done with no effect
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int FRAME_DEPTH = DEF_MAX_SCREEN_WIDTH * DEF_MAX_SCREEN_HEIGHT;

  typedef struct {
    logic [31:0] pixel;
    status_t     code;
  } reply_t;

  // Mirror of the raster engine: framebuffer, sprite store and geometry registers
  class raster_scoreboard;
    logic [31:0] frame[FRAME_DEPTH];
    logic [31:0] sprite[DEF_SPRITE_WORDS];
    int          scr_w, scr_h, spr_w, spr_h;
    reply_t      replies[$];
    int          errors;
    int          checked;

    function void write_reg(reg_idx_t idx, logic [8:0] val);
      case (idx)
        REG_SCREEN_WIDTH:  scr_w = val;
        REG_SCREEN_HEIGHT: scr_h = val;
        REG_SPRITE_WIDTH:  spr_w = val[6:0];
        REG_SPRITE_HEIGHT: spr_h = val[6:0];
        default: ;
      endcase
    endfunction

    function int act_w();
      return (scr_w > DEF_MAX_SCREEN_WIDTH) ? DEF_MAX_SCREEN_WIDTH : scr_w;
    endfunction

    function int act_h();
      return (scr_h > DEF_MAX_SCREEN_HEIGHT) ? DEF_MAX_SCREEN_HEIGHT : scr_h;
    endfunction

    function int clip(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function void paint(int x0, int x1, int y0, int y1, logic [31:0] c);
      int w;
      w = act_w();
      for (int y = y0; y < y1; y++)
        for (int x = x0; x < x1; x++)
          frame[(y * w + x) % FRAME_DEPTH] = c;
    endfunction

    function void draw_sprite(int left, int bottom, int s, logic [31:0] key, bit mirror);
      int w, h, x0, x1, y0, y1, row, col;
      logic [31:0] p;
      w  = act_w();
      h  = act_h();
      x0 = clip(left, w);
      y0 = clip(bottom, h);
      x1 = clip(spr_w / s + left, w);
      y1 = clip(spr_h / s + bottom, h);
      for (int y = y0; y < y1; y++) begin
        row = (y - bottom) * s + s / 2;
        for (int x = x0; x < x1; x++) begin
          col = (x - left) * s + s / 2;
          if (mirror) col = spr_w - 1 - col;
          p = sprite[(row * spr_w + col) % DEF_SPRITE_WORDS];
          if (p != key) frame[(y * w + x) % FRAME_DEPTH] = p;
        end
      end
    endfunction

    // Apply one accepted command and queue its reply
    function void note_command(logic [2:0] op, logic signed [15:0] xs, logic signed [15:0] xe,
                               logic signed [15:0] ys, logic signed [15:0] ye,
                               logic [3:0] sc, logic [31:0] c, logic [11:0] idx);
      reply_t r;
      int w, h;
      w = act_w();
      h = act_h();
      r.pixel = '0;
      r.code  = ST_DONE;
      case (op)
        OP_FILL:  paint(clip(xs, w), clip(xe, w), clip(ys, h), clip(ye, h), c);
        OP_CLEAR: paint(0, w, 0, h, c);
        OP_BLIT, OP_BLIT_MIRROR: begin
          if (sc == 0) r.code = ST_IGNORED;
          else draw_sprite(xs, ys, sc, c, op == OP_BLIT_MIRROR);
        end
        OP_LOAD:  sprite[idx] = c;
        OP_READ: begin
          if (xs >= 0 && xs < w && ys >= 0 && ys < h) r.pixel = frame[(ys * w + xs) % FRAME_DEPTH];
          else r.code = ST_OUTSIDE;
        end
        default: ;
      endcase
      replies.push_back(r);
    endfunction

    function void check(logic [31:0] pixel, logic [1:0] code);
      reply_t r;
      if (replies.size() == 0) begin
        $error("result with no command outstanding: read_color %h status %0d", pixel, code);
        errors++;
        return;
      end
      r = replies.pop_front();
      checked++;
      if (pixel !== r.pixel) begin
        $error("read_color mismatch: expected %h, got %h", r.pixel, pixel);
        errors++;
      end
      if (code !== r.code) begin
        $error("status mismatch: expected %0d, got %0d", r.code, code);
        errors++;
      end
    endfunction
  endclass

  logic               clk, rst, start, busy, cfg_we, done;
  logic [2:0]         op;
  logic signed [15:0] x_start, x_end, y_start, y_end;
  logic [3:0]         scale;
  logic [31:0]        color, read_color;
  logic [11:0]        sprite_index;
  logic [1:0]         cfg_index, status;
  logic [8:0]         cfg_data;

  raster_scoreboard raster_sb = new();
  int               gap_pct;
  int               rand_issued;
  int               cmd_count;
  logic [31:0]      palette[4];

  raster_fill_and_sprite_blit_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .x_start(x_start), .x_end(x_end), .y_start(y_start), .y_end(y_end),
    .scale(scale), .color(color), .sprite_index(sprite_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .read_color(read_color), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && done) raster_sb.check(read_color, status);
  end

  // Issue one command and hold it until the block takes it
  task automatic send_cmd(logic [2:0] o, logic signed [15:0] xs, logic signed [15:0] xe,
                          logic signed [15:0] ys, logic signed [15:0] ye,
                          logic [3:0] sc, logic [31:0] c, logic [11:0] idx);
    gap_pct = (cmd_count < 193) ? 29 : (cmd_count < 387) ? 84 : 0;
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    op = o; x_start = xs; x_end = xe; y_start = ys; y_end = ye;
    scale = sc; color = c; sprite_index = idx;
    raster_sb.note_command(o, xs, xe, ys, ye, sc, c, idx);
    cmd_count++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Write one register once all replies are in
  task automatic write_reg(reg_idx_t idx, logic [8:0] val);
    while (raster_sb.replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    raster_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [15:0] pick(int lo, int hi);
    if ($urandom_range(19) == 0) return $urandom;
    return $urandom_range(hi - lo) + lo;
  endfunction

  function automatic logic [31:0] pick_color();
    if ($urandom_range(9) < 7) return palette[$urandom_range(3)];
    return $urandom;
  endfunction

  // Configure geometry, then clear the screen and load the whole sprite
  task automatic setup_phase(int w, int h, int sw, int sh);
    write_reg(REG_SCREEN_WIDTH, 9'(w));
    write_reg(REG_SCREEN_HEIGHT, 9'(h));
    write_reg(REG_SPRITE_WIDTH, 9'(sw));
    write_reg(REG_SPRITE_HEIGHT, 9'(sh));
    send_cmd(OP_CLEAR, 0, 0, 0, 0, 0, $urandom, 0);
    for (int i = 0; i < sw * sh; i++) send_cmd(OP_LOAD, 0, 0, 0, 0, 0, pick_color(), 12'(i));
  endtask

  task automatic random_cmds(int n);
    int w, h, r, sw, sh;
    logic [31:0] key;
    w  = raster_sb.act_w();
    h  = raster_sb.act_h();
    sw = raster_sb.spr_w;
    sh = raster_sb.spr_h;
    for (int i = 0; i < n; i++) begin
      rand_issued++;
      r = $urandom_range(99);
      if (r < 33 && !(r >= 30 && w * h <= 8192)) begin
        // small rectangles mostly; pick() adds an occasional wild edge
        int x0, y0;
        x0 = $urandom_range(w + 16) - 8;
        y0 = $urandom_range(h + 16) - 8;
        send_cmd(OP_FILL, pick(x0, x0), pick(x0 - 2, x0 + 24), pick(y0, y0),
                 pick(y0 - 2, y0 + 24), $urandom, $urandom, $urandom);
      end else if (r < 33) begin
        send_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 70) begin
        key = (sw * sh > 0 && $urandom_range(1)) ?
              raster_sb.sprite[$urandom_range(sw * sh - 1)] : pick_color();
        send_cmd((r < 55) ? OP_BLIT : OP_BLIT_MIRROR, pick(-sw, w + 4), $urandom,
                 pick(-sh, h + 4), $urandom, $urandom_range(15), key, $urandom);
      end else if (r < 80) begin
        send_cmd(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, pick_color(),
                 ($urandom_range(1) && sw * sh > 0) ? $urandom_range(sw * sh - 1) :
                 $urandom_range(4095));
      end else if (r < 97) begin
        send_cmd(OP_READ, pick(-3, w + 2), $urandom, pick(-3, h + 2), $urandom,
                 $urandom, $urandom, $urandom);
      end else begin
        send_cmd(r[0] ? OP_SPARE_LO : OP_SPARE_HI, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0; op = '0; x_start = '0; x_end = '0; y_start = '0; y_end = '0;
    scale = '0; color = '0; sprite_index = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    gap_pct = 0; rand_issued = 0; cmd_count = 0;
    raster_sb.errors = 0; raster_sb.checked = 0;
    raster_sb.scr_w = 0; raster_sb.scr_h = 0; raster_sb.spr_w = 0; raster_sb.spr_h = 0;
    foreach (palette[i]) palette[i] = $urandom;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Zero-sized screen and sprite: reads fall outside, draws touch nothing
    setup_phase(0, 0, 0, 0);
    random_cmds(15);

    // Directed corner cases on a small screen
    setup_phase(16, 12, 8, 6);
    send_cmd(OP_FILL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 4'hf, 32'hffff_ffff, 12'hfff);
    send_cmd(OP_FILL, 10, 4, 2, 9, 0, 32'h0, 0);
    send_cmd(OP_FILL, 16'sh7fff, 16'sh8000, 3, 5, 0, 32'h1234_5678, 0);
    send_cmd(OP_FILL, 15, 17, 11, 40, 0, 32'h5a5a_a5a5, 0);
    send_cmd(OP_BLIT, 0, 0, 0, 0, 0, 32'h0, 0);
    send_cmd(OP_BLIT_MIRROR, 2, 0, 2, 0, 0, 32'h0, 0);
    send_cmd(OP_BLIT, 0, 0, 0, 0, 1, 32'hdead_beef, 0);
    send_cmd(OP_BLIT, -3, 0, -2, 0, 1, palette[0], 0);
    send_cmd(OP_BLIT_MIRROR, 5, 0, 4, 0, 2, palette[1], 0);
    send_cmd(OP_BLIT, 12, 0, 9, 0, 15, 32'h0, 0);
    send_cmd(OP_BLIT_MIRROR, 13, 0, 10, 0, 1, 32'h0, 0);
    send_cmd(OP_LOAD, 0, 0, 0, 0, 0, 32'hffff_ffff, 12'hfff);
    send_cmd(OP_LOAD, 0, 0, 0, 0, 0, 32'h0, 12'h000);
    send_cmd(OP_BLIT, 0, 0, 0, 0, 3, 32'h1, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_READ, 15, 0, 11, 0, 0, 0, 0);
    send_cmd(OP_READ, -1, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_READ, 16, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_READ, 0, 0, 12, 0, 0, 0, 0);
    send_cmd(OP_READ, 16'sh8000, 0, 16'sh7fff, 0, 0, 0, 0);
    send_cmd(OP_SPARE_LO, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 4'hf, 32'hffff_ffff, 12'hfff);
    send_cmd(OP_SPARE_HI, 0, 0, 0, 0, 0, 0, 0);
    random_cmds(60);

    // Oversized width saturates; widest sprite in this bench
    setup_phase(300, 40, 64, 2);
    random_cmds(30);
    // Full height, tallest sprite in this bench
    setup_phase(40, 256, 1, 64);
    random_cmds(30);
    setup_phase(256, 256, 5, 7);
    random_cmds(15);
    // Both screen registers at their top code, one-pixel sprite
    setup_phase(511, 511, 1, 1);
    random_cmds(10);
    setup_phase(33, 29, 6, 5);
    random_cmds(45);
    setup_phase(7, 300, 3, 3);
    random_cmds(30);

    while (raster_sb.replies.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Ran %0d commands (%0d random) over eight screen and sprite geometries;",
             cmd_count, rand_issued);
    $display("checked %0d results, %0d mismatches.", raster_sb.checked, raster_sb.errors);
    if (raster_sb.errors == 0 && raster_sb.replies.size() == 0) begin
      $display("[raster_fill_and_sprite_blit_core] OK");
    end else begin
      $display("[raster_fill_and_sprite_blit_core] ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #40_000_000;
    $display("[raster_fill_and_sprite_blit_core] ERROR");
    $finish;
  end

endmodule
